FILE: hdl/dvf_pkg.sv
// Package for the duplicate value finder: sizes, controller states and the
// command/status structs between controller and datapath. No dependencies.
package dvf_pkg;

   localparam int MAX_ELEMENTS = 128;
   localparam int DATA_W       = 32;
   localparam int ADDR_W       = $clog2(MAX_ELEMENTS);
   localparam int COUNT_W      = ADDR_W + 1;

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_FETCH,
      ST_LATCH,
      ST_SCAN,
      ST_FINISH
   } dvf_state_type;

   typedef struct packed {
      logic load;        // store the item on the request channel
      logic fetch;       // read the candidate element at the outer index
      logic latch;       // capture candidate, restart the inner scan
      logic scan;        // issue the next inner read and compare
      logic step;        // record the candidate's verdict, advance outer index
      logic emit_final;  // send the closing result and clear the set
   } dvf_cmd_type;

   typedef struct packed {
      logic scan_done;   // inner scan has compared every stored element
      logic hit;         // candidate is a first occurrence that repeats later
      logic last_index;  // outer index is on the last stored element
      logic out_free;    // output register can take a result this cycle
      logic pend_valid;  // a duplicate is held back awaiting its last flag
   } dvf_sts_type;

endpackage

FILE: hdl/dvf_req_if.sv
// Request channel of the duplicate value finder: valid/ready plus one element.
// Depends on dvf_pkg for the data width.
interface dvf_req_if;
   logic                             valid;
   logic                             ready;
   logic signed [dvf_pkg::DATA_W-1:0] element_value;
   logic                             last_element;

   modport source (output valid, output element_value, output last_element, input ready);
   modport sink   (input valid, input element_value, input last_element, output ready);
endinterface

FILE: hdl/dvf_rsp_if.sv
// Result channel of the duplicate value finder: valid/ready plus one result.
// Depends on dvf_pkg for the data width.
interface dvf_rsp_if;
   logic                             valid;
   logic                             ready;
   logic signed [dvf_pkg::DATA_W-1:0] dup_value;
   logic                             found;
   logic                             last_result;
   logic                             truncated;

   modport source (output valid, output dup_value, output found, output last_result,
                   output truncated, input ready);
   modport sink   (input valid, input dup_value, input found, input last_result,
                   input truncated, output ready);
endinterface

FILE: hdl/dvf_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module dvf_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

FILE: hdl/dvf_ctrl.sv
// Controller state machine of the duplicate value finder.
// Depends on dvf_pkg for the state enum and the command/status structs.
module dvf_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_last,
   output logic                 req_ready,
   input  dvf_pkg::dvf_sts_type sts,
   output dvf_pkg::dvf_cmd_type cmd
);
   import dvf_pkg::*;

   dvf_state_type state_ff;
   dvf_state_type state_in;
   logic          step_ok;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

   // a held-back duplicate can only be released into a free output register
   assign step_ok = sts.scan_done && (!(sts.hit && sts.pend_valid) || sts.out_free);

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_LOAD: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               if (req_last) begin
                  state_in = ST_FETCH;
               end
            end
         end
         ST_FETCH: begin
            cmd.fetch = 1'b1;
            state_in  = ST_LATCH;
         end
         ST_LATCH: begin
            cmd.latch = 1'b1;
            state_in  = ST_SCAN;
         end
         ST_SCAN: begin
            cmd.scan = !sts.scan_done;
            if (step_ok) begin
               cmd.step = 1'b1;
               state_in = sts.last_index ? ST_FINISH : ST_FETCH;
            end
         end
         ST_FINISH: begin
            if (sts.out_free) begin
               cmd.emit_final = 1'b1;
               state_in       = ST_LOAD;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end
endmodule

FILE: hdl/dvf_dpath.sv
// Datapath of the duplicate value finder: element store, scan counters,
// comparator, held-back duplicate and output register.
// Depends on dvf_pkg and dvf_ram.
module dvf_dpath (
   input  logic                              clock,
   input  logic                              reset,
   input  dvf_pkg::dvf_cmd_type              cmd,
   output dvf_pkg::dvf_sts_type              sts,
   input  logic signed [dvf_pkg::DATA_W-1:0] req_element_value,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic signed [dvf_pkg::DATA_W-1:0] rsp_dup_value,
   output logic                              rsp_found,
   output logic                              rsp_last_result,
   output logic                              rsp_truncated
);
   import dvf_pkg::*;

   logic [COUNT_W-1:0] count_ff,    count_in;
   logic               overflow_ff, overflow_in;
   logic [ADDR_W-1:0]  i_ff,        i_in;
   logic [COUNT_W-1:0] j_ff,        j_in;
   logic [ADDR_W-1:0]  jd_ff,       jd_in;
   logic               cmp_valid_ff, cmp_valid_in;
   logic               before_ff,   before_in;
   logic               after_ff,    after_in;
   logic [DATA_W-1:0]  x_ff,        x_in;
   logic               pend_valid_ff, pend_valid_in;
   logic [DATA_W-1:0]  pend_ff,     pend_in;
   logic               out_valid_ff, out_valid_in;
   logic [DATA_W-1:0]  out_value_ff, out_value_in;
   logic               out_found_ff, out_found_in;
   logic               out_last_ff,  out_last_in;
   logic               out_trunc_ff, out_trunc_in;

   logic               wr_en;
   logic [ADDR_W-1:0]  rd_addr;
   logic [DATA_W-1:0]  rd_data;
   logic               room;
   logic               issue;
   logic               hit;
   logic               emit_mid;
   logic               out_free;

   assign room     = count_ff < COUNT_W'(MAX_ELEMENTS);
   assign wr_en    = cmd.load && room;
   assign issue    = cmd.scan && (j_ff < count_ff);
   assign rd_addr  = cmd.scan ? j_ff[ADDR_W-1:0] : i_ff;
   assign hit      = after_ff && !before_ff;
   assign out_free = !out_valid_ff || rsp_ready;
   assign emit_mid = cmd.step && hit && pend_valid_ff;

   dvf_ram #(
      .WIDTH (DATA_W),
      .DEPTH (MAX_ELEMENTS)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[ADDR_W-1:0]),
      .wr_data (DATA_W'(req_element_value)),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      count_in      = count_ff;
      overflow_in   = overflow_ff;
      i_in          = i_ff;
      j_in          = j_ff;
      jd_in         = jd_ff;
      cmp_valid_in  = 1'b0;
      before_in     = before_ff;
      after_in      = after_ff;
      x_in          = x_ff;
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      out_value_in  = out_value_ff;
      out_found_in  = out_found_ff;
      out_last_in   = out_last_ff;
      out_trunc_in  = out_trunc_ff;
      out_valid_in  = (out_valid_ff && rsp_ready) ? 1'b0 : out_valid_ff;

      if (cmd.load) begin
         if (room) begin
            count_in = count_ff + COUNT_W'(1);
         end else begin
            overflow_in = 1'b1;
         end
      end

      if (cmd.latch) begin
         x_in      = rd_data;
         j_in      = '0;
         before_in = 1'b0;
         after_in  = 1'b0;
      end

      if (issue) begin
         j_in         = j_ff + COUNT_W'(1);
         jd_in        = j_ff[ADDR_W-1:0];
         cmp_valid_in = 1'b1;
      end

      // compare the element read in the previous cycle against the candidate
      if (cmp_valid_ff && (rd_data == x_ff)) begin
         if (jd_ff < i_ff) begin
            before_in = 1'b1;
         end
         if (jd_ff > i_ff) begin
            after_in = 1'b1;
         end
      end

      if (cmd.step) begin
         i_in = i_ff + ADDR_W'(1);
         if (hit) begin
            pend_in       = x_ff;
            pend_valid_in = 1'b1;
         end
      end

      // release the held-back duplicate now that another one follows it
      if (emit_mid) begin
         out_valid_in = 1'b1;
         out_value_in = pend_ff;
         out_found_in = 1'b1;
         out_last_in  = 1'b0;
         out_trunc_in = overflow_ff;
      end

      if (cmd.emit_final) begin
         out_valid_in  = 1'b1;
         out_value_in  = pend_valid_ff ? pend_ff : '0;
         out_found_in  = pend_valid_ff;
         out_last_in   = 1'b1;
         out_trunc_in  = overflow_ff;
         count_in      = '0;
         overflow_in   = 1'b0;
         pend_valid_in = 1'b0;
         i_in          = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         overflow_ff   <= 1'b0;
         i_ff          <= '0;
         j_ff          <= '0;
         cmp_valid_ff  <= 1'b0;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         count_ff      <= count_in;
         overflow_ff   <= overflow_in;
         i_ff          <= i_in;
         j_ff          <= j_in;
         cmp_valid_ff  <= cmp_valid_in;
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      jd_ff        <= jd_in;
      before_ff    <= before_in;
      after_ff     <= after_in;
      x_ff         <= x_in;
      pend_ff      <= pend_in;
      out_value_ff <= out_value_in;
      out_found_ff <= out_found_in;
      out_last_ff  <= out_last_in;
      out_trunc_ff <= out_trunc_in;
   end

   assign sts.scan_done  = (j_ff == count_ff) && !cmp_valid_ff;
   assign sts.hit        = hit;
   assign sts.last_index = ({1'b0, i_ff} + COUNT_W'(1)) == count_ff;
   assign sts.out_free   = out_free;
   assign sts.pend_valid = pend_valid_ff;

   assign rsp_valid       = out_valid_ff;
   assign rsp_dup_value   = out_value_ff;
   assign rsp_found       = out_found_ff;
   assign rsp_last_result = out_last_ff;
   assign rsp_truncated   = out_trunc_ff;
endmodule

FILE: hdl/duplicate_value_finder_unit.sv
// Loading: one element per cycle while the block waits for a set.
// Search after the last element of a set: each element is read once and then
// compared against the whole store through the single read port of the element
// RAM, one per cycle; a busy output register can hold the search.
// The next set is taken after the closing result enters the output register.
// Reset (synchronous, active high) empties the set; the store needs no clearing.
module duplicate_value_finder_unit (
   input logic       clock,
   input logic       reset,
   dvf_req_if.sink   req,
   dvf_rsp_if.source rsp
);
   import dvf_pkg::*;

   dvf_cmd_type cmd;
   dvf_sts_type sts;

   dvf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_last  (req.last_element),
      .req_ready (req.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   dvf_dpath u_dpath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .req_element_value (req.element_value),
      .rsp_valid         (rsp.valid),
      .rsp_ready         (rsp.ready),
      .rsp_dup_value     (rsp.dup_value),
      .rsp_found         (rsp.found),
      .rsp_last_result   (rsp.last_result),
      .rsp_truncated     (rsp.truncated)
   );

`ifndef SYNTHESIS
   a_cmd_excl: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load, cmd.fetch, cmd.latch, cmd.step, cmd.emit_final}))
      else $error("controller issued conflicting commands");

   a_release_free: assert property (@(posedge clock) disable iff (reset)
      cmd.step && sts.hit && sts.pend_valid |-> sts.out_free)
      else $error("duplicate released into a busy output register");

   a_notfound_last: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.found |-> rsp.last_result && (rsp.dup_value == '0))
      else $error("empty result is not a closing zero result");

   a_final_next_load: assert property (@(posedge clock) disable iff (reset)
      cmd.emit_final |=> req.ready && rsp.valid && rsp.last_result)
      else $error("closing result not presented or set not reopened");
`endif
endmodule

FILE: tb/sv/tb.sv
// Testbench for duplicate_value_finder_unit: drives sets of elements, predicts
// the repeated values of each set and checks every result transfer.
// Depends on dvf_pkg, dvf_req_if, dvf_rsp_if and the unit itself.
module tb;
   import dvf_pkg::*;

   localparam int REPORT_DEPTH = 64;
   localparam int RANDOM_ITEMS = 120;
   localparam int HOLD_CYCLES  = 600;
   localparam int CYCLE_LIMIT  = 400000;

   typedef struct {
      logic signed [DATA_W-1:0] dup_value;
      logic                     found;
      logic                     last_result;
      logic                     truncated;
   } dup_result_type;

   // Holds the current set, works out its repeated values on the last element
   // and compares result transfers against them in order.
   class dup_scoreboard;
      logic signed [DATA_W-1:0] elements [MAX_ELEMENTS];
      int unsigned              n_elements;
      bit                       dropped;
      dup_result_type           expected_q [$];
      int                       errors;

      function new();
         n_elements = 0;
         dropped    = 0;
         errors     = 0;
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      task report(input string msg);
         if (errors < 100) $display("tb: mismatch: %s", msg);
         errors++;
      endtask

      function void note_element(input logic signed [DATA_W-1:0] v, input logic last);
         logic signed [DATA_W-1:0] repeats [$];
         logic signed [DATA_W-1:0] x;
         int unsigned              hits;
         bit                       seen;
         dup_result_type           r;
         if (n_elements < MAX_ELEMENTS) begin
            elements[n_elements] = v;
            n_elements++;
         end else begin
            dropped = 1;
         end
         if (!last) return;
         for (int i = 0; i < n_elements; i++) begin
            x    = elements[i];
            hits = 0;
            for (int j = 0; j < n_elements; j++)
               if (elements[j] == x) hits++;
            seen = 0;
            foreach (repeats[u])
               if (repeats[u] == x) seen = 1;
            if (hits > 1 && !seen && repeats.size() < REPORT_DEPTH) repeats.push_back(x);
         end
         if (repeats.size() == 0) begin
            r.dup_value   = '0;
            r.found       = 1'b0;
            r.last_result = 1'b1;
            r.truncated   = dropped;
            expected_q.push_back(r);
         end else begin
            foreach (repeats[k]) begin
               r.dup_value   = repeats[k];
               r.found       = 1'b1;
               r.last_result = (k == repeats.size() - 1);
               r.truncated   = dropped;
               expected_q.push_back(r);
            end
         end
         n_elements = 0;
         dropped    = 0;
      endfunction

      task check_result(input logic signed [DATA_W-1:0] v, input logic f, input logic l,
                        input logic t);
         dup_result_type r;
         if (expected_q.size() == 0) begin
            report($sformatf("result with none expected: value %0d found %b", v, f));
            return;
         end
         r = expected_q.pop_front();
         if (v !== r.dup_value)
            report($sformatf("dup_value %0d, expected %0d", v, r.dup_value));
         if (f !== r.found)
            report($sformatf("found %b, expected %b (value %0d)", f, r.found, r.dup_value));
         if (l !== r.last_result)
            report($sformatf("last_result %b, expected %b (value %0d)", l, r.last_result,
                             r.dup_value));
         if (t !== r.truncated)
            report($sformatf("truncated %b, expected %b (value %0d)", t, r.truncated,
                             r.dup_value));
      endtask
   endclass

   logic clock;
   logic reset;
   dvf_req_if req_ch ();
   dvf_rsp_if rsp_ch ();

   duplicate_value_finder_unit u_dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   dup_scoreboard            board = new();
   logic signed [DATA_W-1:0] set_buf [$];
   bit                       tx_idle_on   = 1;
   bit                       rx_idle_on   = 1;
   bit                       hold_off_req = 0;
   int                       cycles       = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // Note inputs before results so ordering within the edge does not matter.
   always @(posedge clock) begin
      if (reset === 1'b0) begin
         if (req_ch.valid && req_ch.ready)
            board.note_element(req_ch.element_value, req_ch.last_element);
         if (rsp_ch.valid && rsp_ch.ready)
            board.check_result(rsp_ch.dup_value, rsp_ch.found, rsp_ch.last_result,
                               rsp_ch.truncated);
      end
   end

   // Receiver: random back-pressure, plus one long hold-off on request.
   initial begin
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_req) begin
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_off_req = 0;
         end else begin
            rsp_ch.ready <= !rx_idle_on || ($urandom_range(99) >= 23);
         end
      end
   end

   function logic signed [DATA_W-1:0] pick_value();
      case ($urandom_range(0, 5))
         0:       return 32'sh8000_0000;
         1:       return 32'sh7fff_ffff;
         2:       return $urandom_range(0, 3);
         3:       return 0 - $urandom_range(1, 3);
         default: return $urandom;
      endcase
   endfunction

   task send_element(input logic signed [DATA_W-1:0] v, input logic last);
      while (tx_idle_on && $urandom_range(99) < 23) begin
         req_ch.valid         <= 1'b0;
         req_ch.element_value <= $urandom;
         req_ch.last_element  <= 1'($urandom_range(0, 1));
         @(posedge clock);
      end
      req_ch.valid         <= 1'b1;
      req_ch.element_value <= v;
      req_ch.last_element  <= last;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   task send_set();
      foreach (set_buf[k]) send_element(set_buf[k], k == set_buf.size() - 1);
   endtask

   // Drop valid and hold off new elements until every predicted result has
   // been checked.
   task wait_drained();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (board.pending() != 0) @(posedge clock);
   endtask

   // pool_n of zero draws every element afresh, so repeats are rare.
   task run_random_set(input int n, input int pool_n);
      logic signed [DATA_W-1:0] pool [$];
      pool.delete();
      set_buf.delete();
      repeat (pool_n) pool.push_back(pick_value());
      for (int k = 0; k < n; k++)
         set_buf.push_back(pool_n == 0 ? $urandom : pool[$urandom_range(0, pool_n - 1)]);
      send_set();
   endtask

   // Full store of 64 distinct values, each twice, in shuffled order, then one
   // more element that the full store has to drop.
   task run_full_pairs();
      logic signed [DATA_W-1:0] base;
      logic signed [DATA_W-1:0] tmp;
      int                       j;
      base = $urandom;
      set_buf.delete();
      for (int k = 0; k < MAX_ELEMENTS; k++) set_buf.push_back(base ^ ((k / 2) * 32'h9e37_79b1));
      for (int k = MAX_ELEMENTS - 1; k > 0; k--) begin
         j          = $urandom_range(0, k);
         tmp        = set_buf[k];
         set_buf[k] = set_buf[j];
         set_buf[j] = tmp;
      end
      set_buf.push_back($urandom);
      send_set();
   endtask

   initial begin
      int n;
      int set_idx;
      int sent;
      reset                <= 1'b1;
      req_ch.valid         <= 1'b0;
      req_ch.element_value <= '0;
      req_ch.last_element  <= 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // single element, no repeats
      set_buf = '{32'sh8000_0000};
      send_set();
      // both extremes and zero repeat; zero must read as found
      set_buf = '{32'sh7fff_ffff, 32'sh8000_0000, 0, 32'sh8000_0000, 32'sh7fff_ffff, 0};
      send_set();
      // a value three times is reported once
      set_buf = '{5, 5, 5};
      send_set();
      // all distinct, including a pair of complementary bit patterns
      set_buf = '{-1, 1, 32'sh5555_5555, 32'shaaaa_aaaa};
      send_set();
      set_buf = '{-1, -1};
      send_set();
      wait_drained();

      sent    = 0;
      set_idx = 0;
      while (sent < RANDOM_ITEMS) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5, 6: n = $urandom_range(1, 10);
            7, 8:                n = $urandom_range(11, 24);
            default:             n = $urandom_range(25, 48);
         endcase
         tx_idle_on = !(set_idx >= 4 && set_idx < 8);
         rx_idle_on = tx_idle_on;
         if (set_idx == 2) hold_off_req = 1;
         if ($urandom_range(0, 3) == 0) run_random_set(n, 0);
         else run_random_set(n, $urandom_range(1, n / 2 + 1));
         sent += n;
         if (set_idx == 3 || $urandom_range(0, 9) == 0) wait_drained();
         set_idx++;
      end

      // largest set, with no idling on either side: store exactly full of
      // pairs, then one element dropped
      tx_idle_on = 0;
      rx_idle_on = 0;
      run_full_pairs();
      tx_idle_on = 1;
      rx_idle_on = 1;

      wait_drained();
      repeat (200) @(posedge clock);
      if (board.errors == 0 && board.pending() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

FILE: files.f
hdl/dvf_pkg.sv
hdl/dvf_req_if.sv
hdl/dvf_rsp_if.sv
hdl/dvf_ram.sv
hdl/dvf_ctrl.sv
hdl/dvf_dpath.sv
hdl/duplicate_value_finder_unit.sv
tb/sv/tb.sv
